// ===== hdl/biq_pkg.sv =====
package biq_pkg;

	// Width of one multiplier digit handled per cycle by the serial unit.
	localparam int DIGIT_W = 4;

	// Integer bits of a Q4.x coefficient.
	localparam int COEF_INT_BITS = 4;

	// Extra integer bits of the stored filter value over a sample.
	localparam int STORE_GUARD = 8;

	// Headroom bits of the accumulator over sample plus coefficient width.
	localparam int ACC_GUARD = 11;

	// The accumulator width is capped at this value; the accumulator wraps at its width.
	localparam int MAX_ACC_W = 64;

	// Coefficient register file.
	localparam int NUM_REGS = 7;
	localparam int IDX_W    = 3;

	typedef logic [IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_GAIN_IN_NOW   = 3'd0;
	localparam reg_idx_t REG_GAIN_IN_PREV  = 3'd1;
	localparam reg_idx_t REG_GAIN_IN_PREV2 = 3'd2;
	localparam reg_idx_t REG_GAIN_FB_PREV  = 3'd3;
	localparam reg_idx_t REG_GAIN_FB_PREV2 = 3'd4;
	localparam reg_idx_t REG_WET_GAIN      = 3'd5;
	localparam reg_idx_t REG_DRY_GAIN      = 3'd6;

	// Control from the sequencer to the serial multiply-accumulate unit.
	typedef struct packed {
		logic start;
		logic clear;
		logic negate;
	} mac_ctl_t;

endpackage

// ===== hdl/biq_coef_regs.sv =====
module biq_coef_regs #(
	parameter int COEF_W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  biq_pkg::reg_idx_t     wr_idx,
	input  logic [COEF_W-1:0]     wr_data,
	input  biq_pkg::reg_idx_t     rd_idx,
	output logic [COEF_W-1:0]     rd_data
);
	import biq_pkg::*;

	// Unity gain in Q4.x format.
	localparam logic [COEF_W-1:0] UNITY = COEF_W'(1) << (COEF_W - COEF_INT_BITS);

	logic [COEF_W-1:0] coef_q [NUM_REGS];

	// Register writes; indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= (i == int'(REG_WET_GAIN)) ? UNITY : '0;
			end
		end else if (wr_en && (wr_idx < reg_idx_t'(NUM_REGS))) begin
			coef_q[wr_idx] <= wr_data;
		end
	end

	// Coefficient selected for the current product.
	always_comb begin
		rd_data = '0;
		if (rd_idx < reg_idx_t'(NUM_REGS)) begin
			rd_data = coef_q[rd_idx];
		end
	end

endmodule

// ===== hdl/biq_mac.sv =====
module biq_mac #(
	parameter int ACC_W  = 59,
	parameter int COEF_W = 32,
	parameter int MPL_W  = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  biq_pkg::mac_ctl_t        ctl,
	input  logic signed [COEF_W-1:0] coef,
	input  logic signed [MPL_W-1:0]  opnd,
	output logic                     done,
	output logic signed [ACC_W-1:0]  acc
);
	import biq_pkg::*;

	localparam int NDIG  = MPL_W / DIGIT_W;
	localparam int CNT_W = $clog2(NDIG);

	logic signed [ACC_W-1:0]       mcand_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic [MPL_W-1:0]              mplier_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          running_q;
	logic                          done_q;
	logic                          last;
	logic signed [DIGIT_W:0]       digit;
	logic signed [ACC_W+DIGIT_W:0] term;

	// The top digit of the multiplier carries its sign; the others are unsigned.
	assign last  = (cnt_q == '0);
	assign digit = $signed({last & mplier_q[DIGIT_W-1], mplier_q[DIGIT_W-1:0]});
	assign term  = mcand_q * digit;

	// Digit counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= running_q && last;
			if (ctl.start) begin
				running_q <= 1'b1;
				cnt_q     <= CNT_W'(NDIG - 1);
			end else if (running_q) begin
				if (last) begin
					running_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Shift-and-add datapath: one multiplier digit per cycle.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q  <= ctl.negate ? -ACC_W'(coef) : ACC_W'(coef);
			mplier_q <= opnd;
			if (ctl.clear) begin
				acc_q <= '0;
			end
		end else if (running_q) begin
			acc_q    <= acc_q + term[ACC_W-1:0];
			mcand_q  <= mcand_q <<< DIGIT_W;
			mplier_q <= mplier_q >> DIGIT_W;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

// ===== hdl/biq_rndsat.sv =====
module biq_rndsat #(
	parameter int ACC_W  = 59,
	parameter int FRAC_W = 28,
	parameter int OUT_W  = 24
) (
	input  logic signed [ACC_W-1:0] acc,
	output logic [OUT_W-1:0]        value,
	output logic                    clip
);
	localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_W - 1);
	localparam logic [ACC_W-1:0] HI   = (ACC_W'(1) << (OUT_W - 1)) - ACC_W'(1);
	localparam logic [ACC_W-1:0] LO   = ~HI;

	logic signed [ACC_W-1:0] biased;
	logic signed [ACC_W-1:0] shifted;

	// Round half up, then drop the coefficient fraction bits.
	assign biased  = acc + HALF;
	assign shifted = biased >>> FRAC_W;

	// Clamp to the signed range of the output width.
	always_comb begin
		clip  = 1'b0;
		value = shifted[OUT_W-1:0];
		if (shifted > $signed(HI)) begin
			clip  = 1'b1;
			value = HI[OUT_W-1:0];
		end else if (shifted < $signed(LO)) begin
			clip  = 1'b1;
			value = LO[OUT_W-1:0];
		end
	end

endmodule

// ===== hdl/biquad_iir_with_dry_wet_mix.sv =====
// Channel   Direction  Handshake                Payload
// input     in         in_valid / in_stall      sample_in
// output    out        out_valid / out_stall    sample_out, clipped
// config    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Samples are handled one at a time by the single 4-bit-digit
// multiply-accumulate unit, which forms all seven products in turn, each over
// NDIG = ceil((SAMPLE_WIDTH+8)/4) multiplier digits, six at the default widths.
// A new sample is taken once the previous result sits in the output register,
// even while that result is stalled. Reset clears the delay line and loads the
// default coefficients.
module biquad_iir_with_dry_wet_mix #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           clipped,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  biq_pkg::reg_idx_t              cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_data
);
	import biq_pkg::*;

	localparam int STORE_W = SAMPLE_WIDTH + STORE_GUARD;
	localparam int FULL_W  = SAMPLE_WIDTH + COEF_WIDTH + ACC_GUARD;
	localparam int ACC_W   = (FULL_W > MAX_ACC_W) ? MAX_ACC_W : FULL_W;
	localparam int FRAC_W  = COEF_WIDTH - COEF_INT_BITS;
	localparam int NDIG    = (STORE_W + DIGIT_W - 1) / DIGIT_W;
	localparam int MPL_W   = NDIG * DIGIT_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_FILT  = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]                     state_q;
	reg_idx_t                       prod_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [SAMPLE_WIDTH-1:0] x1_q;
	logic signed [SAMPLE_WIDTH-1:0] x2_q;
	logic signed [STORE_W-1:0]      y_q;
	logic signed [STORE_W-1:0]      y1_q;
	logic signed [STORE_W-1:0]      y2_q;
	logic                           clip_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           clipped_q;

	mac_ctl_t                       mac_ctl;
	logic signed [MPL_W-1:0]        opnd;
	logic [COEF_WIDTH-1:0]          coef;
	logic                           mac_done;
	logic signed [ACC_W-1:0]        acc;
	logic [STORE_W-1:0]             y_rnd;
	logic                           y_clip;
	logic [SAMPLE_WIDTH-1:0]        m_rnd;
	logic                           m_clip;
	logic                           out_free;

	assign cfg_ready = 1'b1;

	biq_coef_regs #(
		.COEF_W (COEF_WIDTH)
	) u_coef_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.rd_idx  (prod_q),
		.rd_data (coef)
	);

	// Operand for the current product; the product index matches the
	// index of its coefficient register.
	always_comb begin
		case (prod_q)
			REG_GAIN_IN_NOW:   opnd = MPL_W'(x_q);
			REG_GAIN_IN_PREV:  opnd = MPL_W'(x1_q);
			REG_GAIN_IN_PREV2: opnd = MPL_W'(x2_q);
			REG_GAIN_FB_PREV:  opnd = MPL_W'(y1_q);
			REG_GAIN_FB_PREV2: opnd = MPL_W'(y2_q);
			REG_WET_GAIN:      opnd = MPL_W'(y_q);
			REG_DRY_GAIN:      opnd = MPL_W'(x_q);
			default:           opnd = '0;
		endcase
	end

	// Feedback terms are subtracted; each of the two sums starts from zero.
	always_comb begin
		mac_ctl.start  = (state_q == ST_START);
		mac_ctl.clear  = (prod_q == REG_GAIN_IN_NOW) || (prod_q == REG_WET_GAIN);
		mac_ctl.negate = (prod_q == REG_GAIN_FB_PREV) || (prod_q == REG_GAIN_FB_PREV2);
	end

	biq_mac #(
		.ACC_W  (ACC_W),
		.COEF_W (COEF_WIDTH),
		.MPL_W  (MPL_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   ($signed(coef)),
		.opnd   (opnd),
		.done   (mac_done),
		.acc    (acc)
	);

	biq_rndsat #(
		.ACC_W  (ACC_W),
		.FRAC_W (FRAC_W),
		.OUT_W  (STORE_W)
	) u_filt_sat (
		.acc   (acc),
		.value (y_rnd),
		.clip  (y_clip)
	);

	biq_rndsat #(
		.ACC_W  (ACC_W),
		.FRAC_W (FRAC_W),
		.OUT_W  (SAMPLE_WIDTH)
	) u_mix_sat (
		.acc   (acc),
		.value (m_rnd),
		.clip  (m_clip)
	);

	assign out_free = !out_valid_q || !out_stall;

	// Sequencer, delay line and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prod_q      <= REG_GAIN_IN_NOW;
			x1_q        <= '0;
			x2_q        <= '0;
			y1_q        <= '0;
			y2_q        <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces or fills the output register; otherwise an
			// accepted output transaction empties it.
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						prod_q  <= REG_GAIN_IN_NOW;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mac_done) begin
						if (prod_q == REG_GAIN_FB_PREV2) begin
							state_q <= ST_FILT;
						end else if (prod_q == REG_DRY_GAIN) begin
							state_q <= ST_OUT;
						end else begin
							prod_q  <= prod_q + 1'b1;
							state_q <= ST_START;
						end
					end
				end
				ST_FILT: begin
					x1_q    <= x_q;
					x2_q    <= x1_q;
					y1_q    <= y_rnd;
					y2_q    <= y1_q;
					clip_q  <= y_clip;
					prod_q  <= REG_WET_GAIN;
					state_q <= ST_START;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sample, filter value and result registers.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			x_q <= sample_in;
		end
		if (state_q == ST_FILT) begin
			y_q <= y_rnd;
		end
		if ((state_q == ST_OUT) && out_free) begin
			sample_out_q <= m_rnd;
			clipped_q    <= clip_q | m_clip;
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

endmodule

// ===== hdl/biq_checker.sv =====
module biq_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [SAMPLE_WIDTH-1:0] sample_out,
	input logic                    clipped
);

	// An accepted sample keeps the input side busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after a transaction");

	// No result appears in the cycle right after a sample is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result appeared immediately after input transaction");

	// A new result is issued together with the return to ready.
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("input still stalled when result was issued");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(sample_out) && $stable(clipped)))
		else $error("stalled output transaction changed");

endmodule

bind biquad_iir_with_dry_wet_mix biq_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_biq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out),
	.clipped    (clipped)
);
